>>> src/bba_pkg.sv
// Package for the buddy block allocator: node marks, command and status codes,
// default sizes. No dependencies.
package bba_pkg;

    localparam int MEM_UNITS_DEF  = 1024;
    localparam int OWNER_BITS_DEF = 8;

    localparam int OWNER_IN_W = 8;
    localparam int ORDER_W    = 4;
    localparam int START_W    = 10;
    localparam int LEN_W      = 11;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 24;

    localparam logic [1:0] MARK_FREE  = 2'd0;
    localparam logic [1:0] MARK_ALLOC = 2'd1;
    localparam logic [1:0] MARK_SPLIT = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_FREED     = 2'd2;
    localparam logic [1:0] ST_NO_OWNER  = 2'd3;

endpackage

>>> src/buddy_block_allocator_top.sv
// Buddy block allocator: node mark/owner memory with a sequencer for allocate
// and free. Depends on bba_pkg.
//
// Each request word gives one result word. After reset the node memory is cleared,
// one node a cycle, through all 2*2^floor(log2(MEM_UNITS)) nodes (2048 at the
// default); no request is taken meanwhile. All node state sits in one single-port
// memory with a registered read, so accesses go one at a time. An allocate walks
// the tree depth first from the root, with a read state and an evaluate state per
// node visited, then writes the block and one split mark per ancestor. A free
// scans every node, one read and one evaluate state each, and then, if the owner
// holds any block, merges buddies bottom up, reading the left child, the right
// child and the parent and then evaluating, for each inner node. A finished result
// waits in the output register while the next request is taken.
module buddy_block_allocator_top #(
    parameter int MEM_UNITS  = bba_pkg::MEM_UNITS_DEF,
    parameter int OWNER_BITS = bba_pkg::OWNER_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bba_pkg::S_DATA_W-1:0] s_tdata,  // owner_id[7:0], block_order[11:8]
    input  logic [0:0]                   s_tuser,  // cmd
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bba_pkg::M_DATA_W-1:0] m_tdata,  // start_unit[9:0], block_length[20:10]
    output logic [1:0]                   m_tuser   // status
);

    localparam int ROOT   = $clog2(MEM_UNITS + 1) - 1;
    localparam int NODE_W = ROOT + 1;
    localparam int NODES  = 1 << NODE_W;
    localparam int LVL_W  = $clog2(ROOT + 2);
    localparam int MW     = OWNER_BITS + 2;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_A_RD, S_A_EV, S_A_UP, S_F_RD, S_F_EV,
        S_M_RL, S_M_RR, S_M_RP, S_M_EV, S_OUT
    } state_t;

    state_t                  state_reg;
    logic [NODE_W-1:0]       idx_reg;
    logic [NODE_W-1:0]       anc_reg;
    logic [NODE_W-1:0]       first_reg;
    logic [LVL_W-1:0]        lvl_reg;
    logic [LVL_W-1:0]        depth_reg;
    logic [LVL_W-1:0]        ord_reg;
    logic [OWNER_BITS-1:0]   own_reg;
    logic                    found_reg;
    logic [1:0]              left_reg;
    logic [1:0]              right_reg;
    logic [1:0]              res_status_reg;
    logic [NODE_W-1:0]       res_start_reg;
    logic [NODE_W-1:0]       res_len_reg;
    logic                    m_tvalid_reg;
    logic [1:0]              m_status_reg;
    logic [bba_pkg::START_W-1:0] m_start_reg;
    logic [bba_pkg::LEN_W-1:0]   m_len_reg;

    logic [MW-1:0]           mem [NODES];
    logic [MW-1:0]           rdata_reg;
    logic                    mem_we;
    logic [NODE_W-1:0]       mem_addr;
    logic [MW-1:0]           mem_wdata;

    logic [1:0]              rd_mark;
    logic [OWNER_BITS-1:0]   rd_owner;
    logic [OWNER_BITS+7:0]   own_ext;
    logic [OWNER_BITS-1:0]   own_in;
    logic [bba_pkg::ORDER_W-1:0] ord_in;
    logic [NODE_W:0]         inc;
    logic [LVL_W-1:0]        tz;
    logic [NODE_W-1:0]       nxt;
    logic [NODE_W-1:0]       target;
    logic [NODE_W-1:0]       a_first;
    logic [LVL_W-1:0]        f_sh;
    logic [NODE_W-1:0]       f_start;
    logic [NODE_W-1:0]       f_len;
    logic                    f_hit;
    logic                    m_merge;

    function automatic logic [LVL_W-1:0] tzc(input logic [NODE_W:0] v);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int i = NODE_W; i >= 0; i--) begin
            if (v[i]) r = LVL_W'(i);
        end
        return r;
    endfunction

    assign rd_mark  = rdata_reg[1:0];
    assign rd_owner = rdata_reg[MW-1:2];
    assign own_ext  = {{OWNER_BITS{1'b0}}, s_tdata[7:0]};
    assign own_in   = own_ext[OWNER_BITS-1:0];
    assign ord_in   = s_tdata[11:8];

    assign inc     = (NODE_W+1)'(idx_reg) + (NODE_W+1)'(1);
    assign tz      = tzc(inc);
    assign nxt     = NODE_W'(inc >> tz);
    assign target  = NODE_W'(idx_reg << (depth_reg - lvl_reg));
    assign a_first = NODE_W'(1) << depth_reg;
    assign f_sh    = LVL_W'(ROOT) - lvl_reg;
    assign f_start = NODE_W'((idx_reg - first_reg) << f_sh);
    assign f_len   = NODE_W'(1) << f_sh;
    assign f_hit   = (rd_mark == bba_pkg::MARK_ALLOC) && (rd_owner == own_reg);
    assign m_merge = (rd_mark != bba_pkg::MARK_FREE) && (rd_mark != bba_pkg::MARK_ALLOC)
                     && (left_reg == bba_pkg::MARK_FREE) && (right_reg == bba_pkg::MARK_FREE);

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = {{OWNER_BITS{1'b0}}, bba_pkg::MARK_FREE};
        unique case (state_reg)
            S_CLR: begin
                mem_we   = 1'b1;
                mem_addr = idx_reg;
            end
            S_A_RD, S_F_RD: mem_addr = idx_reg;
            S_A_EV: begin
                mem_addr = target;
                if (rd_mark == bba_pkg::MARK_FREE) begin
                    mem_we    = 1'b1;
                    mem_wdata = {own_reg, bba_pkg::MARK_ALLOC};
                end
            end
            S_A_UP: begin
                mem_addr  = anc_reg;
                mem_we    = (anc_reg != '0);
                mem_wdata = {{OWNER_BITS{1'b0}}, bba_pkg::MARK_SPLIT};
            end
            S_F_EV: begin
                mem_addr = idx_reg;
                mem_we   = f_hit;
            end
            S_M_RL: mem_addr = NODE_W'({idx_reg, 1'b0});
            S_M_RR: mem_addr = NODE_W'({idx_reg, 1'b1});
            S_M_RP: mem_addr = idx_reg;
            S_M_EV: begin
                mem_addr = idx_reg;
                mem_we   = m_merge;
            end
            S_IDLE, S_OUT: mem_addr = '0;
            default: mem_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_CLR: begin
                    idx_reg <= idx_reg + NODE_W'(1);
                    if (idx_reg == NODE_W'(NODES - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        own_reg   <= own_in;
                        idx_reg   <= NODE_W'(1);
                        lvl_reg   <= '0;
                        first_reg <= NODE_W'(1);
                        found_reg <= 1'b0;
                        if (s_tuser[0] == bba_pkg::CMD_FREE) begin
                            state_reg <= S_F_RD;
                        end else if (32'(ord_in) > 32'(ROOT)) begin
                            res_status_reg <= bba_pkg::ST_NO_FIT;
                            res_start_reg  <= '0;
                            res_len_reg    <= '0;
                            state_reg      <= S_OUT;
                        end else begin
                            ord_reg   <= LVL_W'(ord_in);
                            depth_reg <= LVL_W'(ROOT) - LVL_W'(ord_in);
                            state_reg <= S_A_RD;
                        end
                    end
                end
                S_A_RD: state_reg <= S_A_EV;
                S_A_EV: begin
                    priority if (rd_mark == bba_pkg::MARK_FREE) begin
                        anc_reg        <= target >> 1;
                        res_status_reg <= bba_pkg::ST_ALLOCATED;
                        res_start_reg  <= NODE_W'((target - a_first) << ord_reg);
                        res_len_reg    <= NODE_W'(1) << ord_reg;
                        state_reg      <= S_A_UP;
                    end else if (rd_mark == bba_pkg::MARK_ALLOC || lvl_reg == depth_reg) begin
                        if (nxt == NODE_W'(1)) begin
                            res_status_reg <= bba_pkg::ST_NO_FIT;
                            res_start_reg  <= '0;
                            res_len_reg    <= '0;
                            state_reg      <= S_OUT;
                        end else begin
                            idx_reg   <= nxt;
                            lvl_reg   <= lvl_reg - tz;
                            state_reg <= S_A_RD;
                        end
                    end else begin
                        idx_reg   <= idx_reg << 1;
                        lvl_reg   <= lvl_reg + LVL_W'(1);
                        state_reg <= S_A_RD;
                    end
                end
                S_A_UP: begin
                    anc_reg <= anc_reg >> 1;
                    if (anc_reg == '0) state_reg <= S_OUT;
                end
                S_F_RD: state_reg <= S_F_EV;
                S_F_EV: begin
                    if (f_hit) begin
                        found_reg <= 1'b1;
                        if (!found_reg || f_start < res_start_reg) begin
                            res_start_reg <= f_start;
                            res_len_reg   <= f_len;
                        end
                    end
                    if (idx_reg == NODE_W'(NODES - 1)) begin
                        if (found_reg || f_hit) begin
                            idx_reg   <= NODE_W'(NODES / 2 - 1);
                            state_reg <= S_M_RL;
                        end else begin
                            res_status_reg <= bba_pkg::ST_NO_OWNER;
                            res_start_reg  <= '0;
                            res_len_reg    <= '0;
                            state_reg      <= S_OUT;
                        end
                    end else begin
                        idx_reg <= idx_reg + NODE_W'(1);
                        if (idx_reg == NODE_W'((first_reg << 1) - NODE_W'(1))) begin
                            first_reg <= first_reg << 1;
                            lvl_reg   <= lvl_reg + LVL_W'(1);
                        end
                        state_reg <= S_F_RD;
                    end
                end
                S_M_RL: state_reg <= S_M_RR;
                S_M_RR: begin
                    left_reg  <= rd_mark;
                    state_reg <= S_M_RP;
                end
                S_M_RP: begin
                    right_reg <= rd_mark;
                    state_reg <= S_M_EV;
                end
                S_M_EV: begin
                    if (idx_reg == NODE_W'(1)) begin
                        res_status_reg <= bba_pkg::ST_FREED;
                        state_reg      <= S_OUT;
                    end else begin
                        idx_reg   <= idx_reg - NODE_W'(1);
                        state_reg <= S_M_RL;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_start_reg  <= bba_pkg::START_W'(res_start_reg);
                        m_len_reg    <= bba_pkg::LEN_W'(res_len_reg);
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = bba_pkg::M_DATA_W'({m_len_reg, m_start_reg});

`ifndef SYNTHESIS
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("node memory written while idle");
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == bba_pkg::ST_NO_FIT || m_tuser == bba_pkg::ST_NO_OWNER))
        |-> (m_tdata == '0))
        else $error("failure result carries a block");
`endif

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for buddy_block_allocator_top: a scoreboard class
// mirrors the node tree and checks each result word. Depends on bba_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TREE_ORD = 10;
    localparam int NODES    = 2 << TREE_ORD;

    typedef struct packed {
        logic [1:0]       status;
        logic [bba_pkg::START_W-1:0] start_unit;
        logic [bba_pkg::LEN_W-1:0]   block_length;
    } alloc_result_t;

    class alloc_scoreboard;
        logic [1:0]     mark [NODES];
        logic [7:0]     owner [NODES];
        alloc_result_t  pending [$];
        int             errors;
        int             n_checked;
        int             n_status [4];

        function new();
            foreach (mark[i]) mark[i] = bba_pkg::MARK_FREE;
            errors = 0;
            n_checked = 0;
            foreach (n_status[i]) n_status[i] = 0;
        endfunction

        function alloc_result_t do_alloc(logic [7:0] id, int ord);
            alloc_result_t r;
            int first;
            bit blocked;
            r = '{bba_pkg::ST_NO_FIT, '0, '0};
            if (ord > TREE_ORD) return r;
            first = 1 << (TREE_ORD - ord);
            for (int n = first; n < 2 * first; n++) begin
                if (mark[n] != bba_pkg::MARK_FREE) continue;
                blocked = 0;
                for (int a = n >> 1; a >= 1; a >>= 1)
                    if (mark[a] == bba_pkg::MARK_ALLOC) blocked = 1;
                if (blocked) continue;
                mark[n] = bba_pkg::MARK_ALLOC;
                owner[n] = id;
                for (int a = n >> 1; a >= 1; a >>= 1) mark[a] = bba_pkg::MARK_SPLIT;
                r.status = bba_pkg::ST_ALLOCATED;
                r.start_unit = bba_pkg::START_W'((n - first) << ord);
                r.block_length = bba_pkg::LEN_W'(1 << ord);
                return r;
            end
            return r;
        endfunction

        function alloc_result_t do_free(logic [7:0] id);
            alloc_result_t r;
            int lvl, len, st, best_st, best_len;
            bit found;
            found = 0;
            best_st = 0;
            best_len = 0;
            for (int n = 1; n < NODES; n++) begin
                if (mark[n] == bba_pkg::MARK_ALLOC && owner[n] == id) begin
                    lvl = $clog2(n + 1) - 1;
                    len = 1 << (TREE_ORD - lvl);
                    st = (n - (1 << lvl)) * len;
                    if (!found || st < best_st) begin
                        best_st = st;
                        best_len = len;
                    end
                    found = 1;
                    mark[n] = bba_pkg::MARK_FREE;
                end
            end
            if (!found) return '{bba_pkg::ST_NO_OWNER, '0, '0};
            for (int n = NODES / 2 - 1; n >= 1; n--)
                if (mark[n] != bba_pkg::MARK_FREE && mark[n] != bba_pkg::MARK_ALLOC &&
                    mark[2*n] == bba_pkg::MARK_FREE && mark[2*n+1] == bba_pkg::MARK_FREE)
                    mark[n] = bba_pkg::MARK_FREE;
            r.status = bba_pkg::ST_FREED;
            r.start_unit = bba_pkg::START_W'(best_st);
            r.block_length = bba_pkg::LEN_W'(best_len);
            return r;
        endfunction

        function void note_request(logic cmd, logic [7:0] id, logic [3:0] ord);
            if (cmd == bba_pkg::CMD_ALLOC) pending.push_back(do_alloc(id, int'(ord)));
            else pending.push_back(do_free(id));
        endfunction

        function void check_result(logic [1:0] st, logic [bba_pkg::START_W-1:0] su,
                                   logic [bba_pkg::LEN_W-1:0] bl);
            alloc_result_t e;
            if (pending.size() == 0) begin
                $error("unexpected result word: status %0d start %0d length %0d",
                       st, su, bl);
                errors++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            n_status[st]++;
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (su !== e.start_unit) begin
                $error("start_unit: expected %0d, got %0d", e.start_unit, su);
                errors++;
            end
            if (bl !== e.block_length) begin
                $error("block_length: expected %0d, got %0d", e.block_length, bl);
                errors++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [bba_pkg::S_DATA_W-1:0] s_tdata;
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [bba_pkg::M_DATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;

    alloc_scoreboard sb;
    int send_idle_pct;
    int sink_stall_pct;
    int n_sent;

    buddy_block_allocator_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #1500000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: check on handshake, then pick next tready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[bba_pkg::START_W-1:0],
                            m_tdata[bba_pkg::START_W+bba_pkg::LEN_W-1:bba_pkg::START_W]);
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_word(logic cmd, logic [7:0] id, logic [3:0] ord);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, ord, id};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, id, ord);
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic random_words(int count);
        logic [7:0] id;
        logic       cmd;
        logic [3:0] ord;
        for (int i = 0; i < count; i++) begin
            cmd = ($urandom_range(99) < 35) ? bba_pkg::CMD_FREE : bba_pkg::CMD_ALLOC;
            id  = ($urandom_range(99) < 80) ? 8'($urandom_range(15)) : 8'($urandom);
            if ($urandom_range(99) < 8) ord = 4'($urandom_range(11, 15));
            else if ($urandom_range(99) < 50) ord = 4'($urandom_range(4));
            else ord = 4'($urandom_range(10));
            send_word(cmd, id, ord);
        end
    endtask

    initial begin
        sb = new();
        n_sent = 0;
        send_idle_pct = 0;
        sink_stall_pct = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, oversized orders, unknown owner, multi-block owner
        send_word(bba_pkg::CMD_FREE,  8'd255, 4'd0);
        send_word(bba_pkg::CMD_ALLOC, 8'd255, 4'd10);
        send_word(bba_pkg::CMD_ALLOC, 8'd1,   4'd0);
        send_word(bba_pkg::CMD_FREE,  8'd255, 4'd15);
        send_word(bba_pkg::CMD_ALLOC, 8'd0,   4'd11);
        send_word(bba_pkg::CMD_ALLOC, 8'd0,   4'd15);
        send_word(bba_pkg::CMD_ALLOC, 8'd0,   4'd0);
        send_word(bba_pkg::CMD_ALLOC, 8'd7,   4'd3);
        send_word(bba_pkg::CMD_ALLOC, 8'd0,   4'd0);
        send_word(bba_pkg::CMD_ALLOC, 8'd7,   4'd1);
        send_word(bba_pkg::CMD_ALLOC, 8'd170, 4'd9);
        send_word(bba_pkg::CMD_ALLOC, 8'd85,  4'd9);
        send_word(bba_pkg::CMD_ALLOC, 8'd2,   4'd0);
        send_word(bba_pkg::CMD_FREE,  8'd7,   4'd0);
        send_word(bba_pkg::CMD_FREE,  8'd0,   4'd0);
        send_word(bba_pkg::CMD_FREE,  8'd170, 4'd0);
        send_word(bba_pkg::CMD_FREE,  8'd85,  4'd0);
        send_word(bba_pkg::CMD_FREE,  8'd2,   4'd0);
        send_word(bba_pkg::CMD_ALLOC, 8'd3,   4'd10);
        send_word(bba_pkg::CMD_FREE,  8'd3,   4'd12);
        drain();

        random_words(260);
        drain();
        send_idle_pct = 85;
        random_words(260);
        drain();
        send_idle_pct = 0;
        sink_stall_pct = 85;
        random_words(260);
        drain();
        send_idle_pct = 17;
        sink_stall_pct = 17;
        random_words(260);
        drain();

        repeat (100) @(posedge aclk);
        $display("Covered %0d requests, %0d results: allocated %0d, no fit %0d,",
                 n_sent, sb.n_checked, sb.n_status[0], sb.n_status[1]);
        $display("freed %0d, owner missing %0d, under four idle/stall mixes.",
                 sb.n_status[2], sb.n_status[3]);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
